// ----- hw/rtl/acds_pkg.sv -----
// ----------------------------------------------------------------------------
// acds_pkg
// Shared types, constants and the microprogram of the audio clock divider
// search core.
// ----------------------------------------------------------------------------
package acds_pkg;

   localparam int RATIO_COUNT = 4;
   localparam int REG_COUNT   = 4;
   localparam int RATIO_W     = 10;
   localparam int CLK_W       = 32;
   localparam int RATE_W      = 18;
   localparam int PROD_W      = RATIO_W + CLK_W;
   localparam int SLOT_W      = $clog2(RATIO_COUNT + 1);
   localparam int REG_IDX_W   = $clog2(REG_COUNT);
   localparam int DIV_CNT_W   = $clog2(CLK_W);
   localparam int PC_W        = 4;

   localparam logic [RATIO_W-1:0] RATIO_RESET [REG_COUNT] =
      '{10'd256, 10'd512, 10'd384, 10'd768};

   typedef logic [REG_COUNT-1:0][RATIO_W-1:0] ratio_array_type;

   typedef struct packed {
      logic [CLK_W-1:0]  source_clock_rate;
      logic [RATE_W-1:0] sample_rate;
   } req_type;

   typedef struct packed {
      logic [RATIO_W-1:0] chosen_ratio;
      logic [CLK_W-1:0]   clock_divider;
   } rsp_type;

   typedef enum logic [PC_W-1:0] {
      S_WAIT      = 4'd0,
      S_CHECK_END = 4'd1,
      S_CHECK_SKP = 4'd2,
      S_DIV_FS    = 4'd3,
      S_WAIT_FS   = 4'd4,
      S_DIV_RATE  = 4'd5,
      S_WAIT_RATE = 4'd6,
      S_ROUND     = 4'd7,
      S_TEST_MUL  = 4'd8,
      S_DIV_ACT   = 4'd9,
      S_WAIT_ACT  = 4'd10,
      S_DEV       = 4'd11,
      S_NEXT      = 4'd12,
      S_DONE      = 4'd13
   } step_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_IDLE,
      C_SLOT_END,
      C_SKIP,
      C_DIV_BUSY,
      C_DIV_SMALL,
      C_EXACT
   } cond_type;

   typedef enum logic [3:0] {
      A_NONE,
      A_LOAD,
      A_DIV_FS,
      A_DIV_RATE,
      A_ROUND,
      A_MUL,
      A_DIV_ACT,
      A_DEV,
      A_NEXT,
      A_DONE
   } action_type;

   typedef struct packed {
      cond_type   cond;
      step_type   target;
      action_type action;
   } ctrl_word_type;

   typedef struct packed {
      logic slot_end;
      logic skip;
      logic div_busy;
      logic div_small;
      logic exact;
   } status_type;

   // The control store. When the condition holds the sequencer jumps to the
   // target, otherwise it steps to the next word.
   function automatic ctrl_word_type program_word(input step_type pc);
      ctrl_word_type w;
      begin
         w = '{cond: C_ALWAYS, target: S_WAIT, action: A_NONE};
         case (pc)
            S_WAIT:      w = '{cond: C_IDLE,      target: S_WAIT,      action: A_LOAD};
            S_CHECK_END: w = '{cond: C_SLOT_END,  target: S_DONE,      action: A_NONE};
            S_CHECK_SKP: w = '{cond: C_SKIP,      target: S_NEXT,      action: A_NONE};
            S_DIV_FS:    w = '{cond: C_NONE,      target: S_WAIT,      action: A_DIV_FS};
            S_WAIT_FS:   w = '{cond: C_DIV_BUSY,  target: S_WAIT_FS,   action: A_NONE};
            S_DIV_RATE:  w = '{cond: C_NONE,      target: S_WAIT,      action: A_DIV_RATE};
            S_WAIT_RATE: w = '{cond: C_DIV_BUSY,  target: S_WAIT_RATE, action: A_NONE};
            S_ROUND:     w = '{cond: C_NONE,      target: S_WAIT,      action: A_ROUND};
            S_TEST_MUL:  w = '{cond: C_DIV_SMALL, target: S_NEXT,      action: A_MUL};
            S_DIV_ACT:   w = '{cond: C_NONE,      target: S_WAIT,      action: A_DIV_ACT};
            S_WAIT_ACT:  w = '{cond: C_DIV_BUSY,  target: S_WAIT_ACT,  action: A_NONE};
            S_DEV:       w = '{cond: C_EXACT,     target: S_DONE,      action: A_DEV};
            S_NEXT:      w = '{cond: C_ALWAYS,    target: S_CHECK_END, action: A_NEXT};
            S_DONE:      w = '{cond: C_ALWAYS,    target: S_WAIT,      action: A_DONE};
            default:     w = '{cond: C_ALWAYS,    target: S_WAIT,      action: A_NONE};
         endcase
         return w;
      end
   endfunction

endpackage

// ----- hw/rtl/acds_divider.sv -----
// ----------------------------------------------------------------------------
// acds_divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acds_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [acds_pkg::CLK_W-1:0]     dividend,
   input  logic [acds_pkg::PROD_W-1:0]    divisor,
   output logic                           busy,
   output logic [acds_pkg::CLK_W-1:0]     quotient,
   output logic [acds_pkg::PROD_W-1:0]    remainder
);

   logic                              busy_ff, busy_in;
   logic [acds_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [acds_pkg::CLK_W-1:0]        quo_ff, quo_in;
   logic [acds_pkg::PROD_W-1:0]       rem_ff, rem_in;
   logic [acds_pkg::PROD_W-1:0]       dvs_ff, dvs_in;
   logic [acds_pkg::PROD_W:0]         trial;
   logic [acds_pkg::PROD_W:0]         diff;
   logic                              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[acds_pkg::CLK_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[acds_pkg::CLK_W-2:0], fits};
         rem_in = fits ? diff[acds_pkg::PROD_W-1:0] : trial[acds_pkg::PROD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == acds_pkg::DIV_CNT_W'(acds_pkg::CLK_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/acds_datapath.sv -----
// ----------------------------------------------------------------------------
// acds_datapath
// Operand registers, shared divider, multiplier and best-candidate tracking.
// ----------------------------------------------------------------------------
module acds_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  acds_pkg::req_type             req_word,
   input  acds_pkg::ratio_array_type     ratios,
   input  acds_pkg::action_type          action,
   output acds_pkg::status_type          status,
   output acds_pkg::rsp_type             best
);

   logic [acds_pkg::CLK_W-1:0]     clk_ff, clk_in;
   logic [acds_pkg::RATE_W-1:0]    rate_ff, rate_in;
   logic [acds_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [acds_pkg::CLK_W-1:0]     div_ff, div_in;
   logic [acds_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic                           have_ff, have_in;
   logic [acds_pkg::RATIO_W-1:0]   best_ratio_ff, best_ratio_in;
   logic [acds_pkg::CLK_W-1:0]     best_clkdiv_ff, best_clkdiv_in;
   logic [acds_pkg::CLK_W-1:0]     best_dev_ff, best_dev_in;

   logic [acds_pkg::RATIO_W-1:0]   ratio;
   logic                           dv_start;
   logic [acds_pkg::CLK_W-1:0]     dv_dividend;
   logic [acds_pkg::PROD_W-1:0]    dv_divisor;
   logic                           dv_busy;
   logic [acds_pkg::CLK_W-1:0]     dv_quo;
   logic [acds_pkg::PROD_W-1:0]    dv_rem;
   logic                           round_up;
   logic [acds_pkg::CLK_W:0]       round_sum;
   logic [acds_pkg::CLK_W-1:0]     rate_ext;
   logic [acds_pkg::CLK_W-1:0]     dev;

   acds_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (dv_start),
      .dividend  (dv_dividend),
      .divisor   (dv_divisor),
      .busy      (dv_busy),
      .quotient  (dv_quo),
      .remainder (dv_rem)
   );

   always_comb begin
      if (slot_ff < acds_pkg::SLOT_W'(acds_pkg::REG_COUNT)) begin
         ratio = ratios[slot_ff[acds_pkg::REG_IDX_W-1:0]];
      end else begin
         ratio = '0;
      end

      rate_ext  = acds_pkg::CLK_W'(rate_ff);
      dev       = (dv_quo >= rate_ext) ? dv_quo - rate_ext : rate_ext - dv_quo;
      round_up  = dv_rem > acds_pkg::PROD_W'(rate_ff >> 1);
      round_sum = {1'b0, dv_quo} + (acds_pkg::CLK_W + 1)'(round_up);

      dv_start    = 1'b0;
      dv_dividend = clk_ff;
      dv_divisor  = prod_ff;
      case (action)
         acds_pkg::A_DIV_FS: begin
            dv_start   = 1'b1;
            dv_divisor = acds_pkg::PROD_W'(ratio);
         end
         acds_pkg::A_DIV_RATE: begin
            dv_start    = 1'b1;
            dv_dividend = dv_quo;
            dv_divisor  = acds_pkg::PROD_W'(rate_ff);
         end
         acds_pkg::A_DIV_ACT: begin
            dv_start = 1'b1;
         end
         default: begin
            dv_start = 1'b0;
         end
      endcase

      clk_in         = clk_ff;
      rate_in        = rate_ff;
      slot_in        = slot_ff;
      div_in         = div_ff;
      prod_in        = prod_ff;
      have_in        = have_ff;
      best_ratio_in  = best_ratio_ff;
      best_clkdiv_in = best_clkdiv_ff;
      best_dev_in    = best_dev_ff;
      case (action)
         acds_pkg::A_LOAD: begin
            if (start) begin
               clk_in         = req_word.source_clock_rate;
               rate_in        = req_word.sample_rate;
               slot_in        = '0;
               have_in        = 1'b0;
               best_ratio_in  = '0;
               best_clkdiv_in = '0;
               best_dev_in    = '0;
            end
         end
         acds_pkg::A_ROUND: begin
            div_in = round_sum[acds_pkg::CLK_W] ? '1 : round_sum[acds_pkg::CLK_W-1:0];
         end
         acds_pkg::A_MUL: begin
            prod_in = acds_pkg::PROD_W'(ratio) * acds_pkg::PROD_W'(div_ff);
         end
         acds_pkg::A_DEV: begin
            if (!have_ff || dev < best_dev_ff) begin
               have_in        = 1'b1;
               best_ratio_in  = ratio;
               best_clkdiv_in = div_ff;
               best_dev_in    = dev;
            end
         end
         acds_pkg::A_NEXT: begin
            slot_in = slot_ff + 1'b1;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase

      status.slot_end  = slot_ff >= acds_pkg::SLOT_W'(acds_pkg::RATIO_COUNT);
      status.skip      = (ratio == '0) || (rate_ff == '0);
      status.div_busy  = dv_busy;
      status.div_small = div_ff[acds_pkg::CLK_W-1:1] == '0;
      status.exact     = dev == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      clk_ff         <= clk_in;
      rate_ff        <= rate_in;
      div_ff         <= div_in;
      prod_ff        <= prod_in;
      best_ratio_ff  <= best_ratio_in;
      best_clkdiv_ff <= best_clkdiv_in;
      best_dev_ff    <= best_dev_in;
   end

   assign best.chosen_ratio  = best_ratio_ff;
   assign best.clock_divider = best_clkdiv_ff;

endmodule

// ----- hw/rtl/acds_sequencer.sv -----
// ----------------------------------------------------------------------------
// acds_sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module acds_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  acds_pkg::status_type   status,
   output acds_pkg::action_type   action,
   output logic                   busy
);

   acds_pkg::step_type       pc_ff, pc_in;
   acds_pkg::ctrl_word_type  ctrl;
   logic                     taken;

   always_comb begin
      ctrl = acds_pkg::program_word(pc_ff);
      case (ctrl.cond)
         acds_pkg::C_NONE:      taken = 1'b0;
         acds_pkg::C_ALWAYS:    taken = 1'b1;
         acds_pkg::C_IDLE:      taken = !start;
         acds_pkg::C_SLOT_END:  taken = status.slot_end;
         acds_pkg::C_SKIP:      taken = status.skip;
         acds_pkg::C_DIV_BUSY:  taken = status.div_busy;
         acds_pkg::C_DIV_SMALL: taken = status.div_small;
         acds_pkg::C_EXACT:     taken = status.exact;
         default:               taken = 1'b1;
      endcase
      if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = acds_pkg::step_type'(pc_ff + acds_pkg::PC_W'(1));
      end
      action = ctrl.action;
      busy   = pc_ff != acds_pkg::S_WAIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= acds_pkg::S_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- hw/rtl/audio_clock_divider_search_core.sv -----
// ----------------------------------------------------------------------------
// audio_clock_divider_search_core
// Picks an oversampling ratio and an integer clock divider for an audio
// serial master clock from a source clock and a wanted sample rate.
//
//   channel   ports                               handshake
//   request   start, busy, req_word               taken when start and !busy
//   result    rsp_strobe, rsp_word                one-cycle strobe, no stall
//   config    csr_write, csr_index, csr_data      taken when csr_write
//
// A request steps through up to four ratio slots and runs the divisions
// for each slot that is tried on the shared one-bit-per-cycle divider,
// which sets its run time; a skipped slot takes only the slot checks.
// The result strobe comes in the cycle after the last step, and busy is low
// again in that cycle. Reset loads the default ratios and idles the block.
// ----------------------------------------------------------------------------
module audio_clock_divider_search_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  acds_pkg::req_type                 req_word,
   output logic                              rsp_strobe,
   output acds_pkg::rsp_type                 rsp_word,
   input  logic                              csr_write,
   input  logic [acds_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [acds_pkg::RATIO_W-1:0]      csr_data
);

   acds_pkg::ratio_array_type  ratio_ff, ratio_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   acds_pkg::rsp_type          rsp_word_ff, rsp_word_in;
   acds_pkg::action_type       action;
   acds_pkg::status_type       status;
   acds_pkg::rsp_type          best;

   acds_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .action (action),
      .busy   (busy)
   );

   acds_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_word (req_word),
      .ratios   (ratio_ff),
      .action   (action),
      .status   (status),
      .best     (best)
   );

   always_comb begin
      ratio_in = ratio_ff;
      if (csr_write) begin
         ratio_in[csr_index] = csr_data;
      end
      rsp_strobe_in = action == acds_pkg::A_DONE;
      rsp_word_in   = rsp_strobe_in ? best : rsp_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < acds_pkg::REG_COUNT; i++) begin
            ratio_ff[i] <= acds_pkg::RATIO_RESET[i];
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         ratio_ff      <= ratio_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe lasted more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word delivered while still busy");

   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start");

   a_pair_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_word.clock_divider != '0) |->
         (rsp_word.chosen_ratio != '0) && (rsp_word.clock_divider[acds_pkg::CLK_W-1:1] != '0))
      else $error("result word holds an invalid ratio and divider pair");

endmodule
